// ===== design/circular_deque_unit_defines.svh =====
// Assertion macros for the circular deque RTL.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular deque check failed");

`else

`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/cdq_pkg.sv =====
// Types and constants shared by the circular deque modules.
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic [CAP_W-1:0]         occupancy;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
        logic cfg_write;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

// ===== design/cdq_ctrl.sv =====
// Controller state machine that sequences one deque operation at a time.
module cdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    input  logic          cfg_valid,
    input  cdq_pkg::sts_t sts,
    output logic          in_stall,
    output logic          cfg_ready,
    output cdq_pkg::cmd_t cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;
    logic            out_free;

    // The output register can take a result if empty or being drained now.
    assign out_free = !sts.out_busy || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cdq_pkg::S_ACCESS;
                end
            end
            cdq_pkg::S_ACCESS:
            begin
                state_next = cdq_pkg::S_FINISH;
            end
            cdq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cfg_ready     = 1'b0;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.cfg_write = 1'b0;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cfg_ready     = 1'b1;
                cmd.capture   = in_valid;
                cmd.cfg_write = cfg_valid;
            end
            cdq_pkg::S_ACCESS:
            begin
                cmd.exec = 1'b1;
            end
            cdq_pkg::S_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/cdq_datapath.sv =====
// Datapath: slot memory, front and rear indices, occupancy and result register.
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cdq_pkg::cmd_t              cmd,
    input  cdq_pkg::in_item_t          in_item,
    input  logic [cdq_pkg::CAP_W-1:0]  cfg_data,
    input  logic                       out_stall,
    output cdq_pkg::sts_t              sts,
    output logic                       out_valid,
    output cdq_pkg::out_item_t         out_item
);

    localparam int IW      = $clog2(DEPTH);
    localparam int XW      = (IW > cdq_pkg::CAP_W) ? IW : cdq_pkg::CAP_W;
    localparam int CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;
    localparam logic [cdq_pkg::CAP_W-1:0] CAP_LIMIT = cdq_pkg::CAP_W'(CAP_MAX);
    localparam logic [cdq_pkg::CAP_W-1:0] CNT_ONE   = 5'd1;
    localparam logic [IW-1:0]             IDX_ONE   = IW'(1);

    logic signed [cdq_pkg::DATA_W-1:0] slots [DEPTH];

    logic [cdq_pkg::CAP_W-1:0]         cap_reg, cap_next;
    logic [IW-1:0]                     front_reg, front_next;
    logic [IW-1:0]                     rear_reg, rear_next;
    logic [cdq_pkg::CAP_W-1:0]         count_reg, count_next;
    logic [cdq_pkg::OP_W-1:0]          op_reg, op_next;
    logic signed [cdq_pkg::DATA_W-1:0] value_reg, value_next;
    logic [cdq_pkg::STAT_W-1:0]        stat_reg, stat_next;
    logic                              pop_reg, pop_next;
    logic signed [cdq_pkg::DATA_W-1:0] rd_data_reg;
    logic                              out_valid_reg, out_valid_next;
    cdq_pkg::out_item_t                out_item_reg, out_item_next;

    logic [cdq_pkg::CAP_W-1:0] eff_cap;
    logic [cdq_pkg::CAP_W-1:0] cap_last;
    logic [IW-1:0]             idx_last;
    logic                      front_at_last;
    logic                      rear_at_last;
    logic                      is_full;
    logic                      is_empty;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [IW-1:0]             rd_addr;

    // A capacity of zero acts as one; anything above the store saturates.
    assign eff_cap = (cap_reg == '0) ? CNT_ONE :
                     ((cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg);
    assign cap_last      = eff_cap - CNT_ONE;
    assign idx_last      = IW'(XW'(cap_last));
    assign front_at_last = (XW'(front_reg) == XW'(cap_last));
    assign rear_at_last  = (XW'(rear_reg) == XW'(cap_last));
    assign is_full       = (count_reg >= eff_cap);
    assign is_empty      = (count_reg == '0);

    always_comb
    begin
        cap_next   = cap_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        op_next    = op_reg;
        value_next = value_reg;
        stat_next  = stat_reg;
        pop_next   = pop_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_addr    = front_reg;

        if (cmd.cfg_write)
        begin
            // A new capacity empties the queue so indices stay in range.
            cap_next   = cfg_data;
            front_next = '0;
            rear_next  = '0;
            count_next = '0;
        end

        if (cmd.capture)
        begin
            op_next    = in_item.op;
            value_next = in_item.value;
        end

        if (cmd.exec)
        begin
            stat_next = cdq_pkg::STAT_DONE;
            pop_next  = 1'b0;
            case (op_reg)
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        stat_next = cdq_pkg::STAT_FULL;
                    end
                    else if (is_empty)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        count_next = CNT_ONE;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                    end
                    else if (op_reg == cdq_pkg::OP_PUSH_FRONT)
                    begin
                        front_next = (front_reg == '0) ? idx_last : front_reg - IDX_ONE;
                        count_next = count_reg + CNT_ONE;
                        wr_en      = 1'b1;
                        wr_addr    = front_next;
                    end
                    else
                    begin
                        rear_next  = rear_at_last ? '0 : rear_reg + IDX_ONE;
                        count_next = count_reg + CNT_ONE;
                        wr_en      = 1'b1;
                        wr_addr    = rear_next;
                    end
                end
                cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        stat_next = cdq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        pop_next = 1'b1;
                        rd_addr  = (op_reg == cdq_pkg::OP_POP_FRONT) ? front_reg : rear_reg;
                        if (count_reg == CNT_ONE)
                        begin
                            front_next = '0;
                            rear_next  = '0;
                            count_next = '0;
                        end
                        else if (op_reg == cdq_pkg::OP_POP_FRONT)
                        begin
                            front_next = front_at_last ? '0 : front_reg + IDX_ONE;
                            count_next = count_reg - CNT_ONE;
                        end
                        else
                        begin
                            rear_next  = (rear_reg == '0) ? idx_last : rear_reg - IDX_ONE;
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                end
                default:
                begin
                    stat_next = cdq_pkg::STAT_DONE;
                end
            endcase
        end
    end

    // Result register: holds a finished transfer until the consumer takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next          = 1'b1;
            out_item_next.status    = stat_reg;
            out_item_next.occupancy = count_reg;
            if (stat_reg == cdq_pkg::STAT_EMPTY)
            begin
                out_item_next.data = '1;
            end
            else if (pop_reg)
            begin
                out_item_next.data = rd_data_reg;
            end
            else
            begin
                out_item_next.data = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= cdq_pkg::CAP_RESET;
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        stat_reg     <= stat_next;
        pop_reg      <= pop_next;
        out_item_reg <= out_item_next;
    end

    // Slot memory with one write port and a registered read port.
    // The read word is held until the result load, even while the output stalls.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_addr] <= value_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    assign sts.out_busy = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_item     = out_item_reg;

endmodule

// ===== design/circular_deque_unit.sv =====
// Top level of the circular deque: controller, datapath and checks.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   in_item   (op, value)
//   out       output     out_valid / out_stall out_item  (data, status, occupancy)
//   cfg       input      cfg_valid / cfg_ready cfg_data  (capacity)
//
// After the item's transfer, the access state does the slot access with index
// update and registered memory read; the finish state then loads the result once
// the output register is free. A new item is taken only in the idle state, after
// the previous item has passed the controller's access and finish states.
// rst_n clears indices, occupancy and state and sets capacity to 16; slots are
// not cleared. A stalled result waits in its register while the next item is
// taken and worked up to its own result load.

`include "circular_deque_unit_defines.svh"

module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  cdq_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output cdq_pkg::out_item_t        out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);

    cdq_pkg::cmd_t ctl_cmd;
    cdq_pkg::sts_t dp_sts;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .sts       (dp_sts),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (ctl_cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .in_item   (in_item),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .sts       (dp_sts),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // An accepted item reaches the slot access in the following cycle.
    `CDQ_ASSERT_NEXT(a_exec_after_accept, clk, rst_n, in_valid && !in_stall, ctl_cmd.exec)

    // A new result never replaces one that is still stalled.
    `CDQ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, ctl_cmd.load_out, !(out_valid && out_stall))

    // A failed pop reports all ones and an empty queue.
    `CDQ_ASSERT_IMPL(a_empty_pop, clk, rst_n,
                     out_valid && out_item.status == cdq_pkg::STAT_EMPTY,
                     out_item.data == '1 && out_item.occupancy == '0)

endmodule
